### hdl/hex_line_to_le_bytes_top_macros.svh
// assertion helpers used by the top rtl file
`ifndef HEX_LINE_TO_LE_BYTES_TOP_MACROS_SVH
`define HEX_LINE_TO_LE_BYTES_TOP_MACROS_SVH

`ifndef SYNTH
`define HLB_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hlb check failed: same cycle");
`define HLB_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hlb check failed: next cycle");
`else
`define HLB_ASSERT_SAME(label, ante, cons)
`define HLB_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### hdl/hlb_pkg.sv
package hlb_pkg;

	localparam int MAX_BYTES = 4;
	localparam int STORE_DEPTH = 4;
	localparam logic [3:0] DIGIT_SAT = 4'd9;

	localparam logic [7:0] CH_SP = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_LX = 8'h78;
	localparam logic [7:0] CH_UX = 8'h58;

	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_LEN  = 2'd1,
		KIND_CHAR = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		PRE_NONE = 2'd0,
		PRE_ZERO = 2'd1,
		PRE_ZX   = 2'd2
	} pre_t;

	typedef struct packed {
		logic [STORE_DEPTH-1:0][7:0] store;
		logic [3:0] nibble;
		logic [3:0] dcount;
		logic [1:0] raw;
		pre_t       pre;
		logic       bad;
		logic [7:0] badval;
	} line_t;

	// bit 4 flags a legal digit
	function automatic logic [4:0] hex_digit(logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, c[3:0]};
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			r = {1'b1, c[3:0] + 4'd9};
		end
		return r;
	endfunction

	function automatic line_t take_char(line_t s, logic [7:0] c);
		line_t t;
		logic [3:0] pos;
		logic [4:0] h;
		t = s;
		pos = s.dcount;
		h = hex_digit(c);
		if (!(c == CH_SP || c == CH_TAB || c == CH_CR)) begin
			if (s.dcount < DIGIT_SAT) begin
				t.dcount = s.dcount + 4'd1;
			end
			if (!h[4]) begin
				if (!s.bad) begin
					t.bad = 1'b1;
					t.badval = c;
				end
			end else if (!pos[0]) begin
				t.nibble = h[3:0];
			end else if (pos[3:1] < 3'(STORE_DEPTH)) begin
				t.store[pos[2:1]] = {s.nibble, h[3:0]};
			end
		end
		return t;
	endfunction

	// one character that does not end the line, prefix handling included
	function automatic line_t char_step(line_t s, logic [7:0] c);
		line_t t;
		t = s;
		if (s.raw == 2'd0) begin
			if (c == CH_ZERO) begin
				t.pre = PRE_ZERO;
			end else begin
				t = take_char(s, c);
			end
		end else if (s.raw == 2'd1 && s.pre == PRE_ZERO) begin
			if (c == CH_LX || c == CH_UX) begin
				t.pre = PRE_ZX;
			end else begin
				t.pre = PRE_NONE;
				t = take_char(take_char(t, CH_ZERO), c);
			end
		end else begin
			if (s.pre == PRE_ZX) begin
				t.pre = PRE_NONE;
			end
			t = take_char(t, c);
		end
		if (s.raw != 2'd2) begin
			t.raw = s.raw + 2'd1;
		end
		return t;
	endfunction

	// a prefix still held at line end counts as plain characters
	function automatic line_t finish_prefix(line_t s);
		line_t t;
		t = s;
		if (s.pre == PRE_ZERO) begin
			t = take_char(s, CH_ZERO);
		end else if (s.pre == PRE_ZX) begin
			t = take_char(take_char(s, CH_ZERO), CH_LX);
		end
		return t;
	endfunction

	function automatic line_t clear_line(line_t s);
		line_t t;
		t = s;
		t.nibble = 4'd0;
		t.dcount = 4'd0;
		t.raw = 2'd0;
		t.pre = PRE_NONE;
		t.bad = 1'b0;
		t.badval = 8'd0;
		return t;
	endfunction

endpackage

### hdl/hlb_if.sv
interface hlb_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;
	logic       end_of_text;

	modport source (output valid, output char_in, output end_of_text, input ready);
	modport sink (input valid, input char_in, input end_of_text, output ready);
endinterface

interface hlb_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_value;
	logic [1:0] out_kind;
	logic       out_last;

	modport source (output valid, output out_value, output out_kind, output out_last,
		input ready);
	modport sink (input valid, input out_value, input out_kind, input out_last,
		output ready);
endinterface

### hdl/hex_line_to_le_bytes_top.sv
// Hex line decoder: takes one text character per cycle while no line end is
// held back and, at each newline or end_of_text, emits the 1, 2 or 4 decoded
// bytes of the line lowest byte first, out_last set on the final one. A
// character is registered, then decoded into the line state; a line end loads
// the results from the input register into a four-entry result buffer. They
// leave it at one per cycle while the receiver is ready, and ordinary
// characters keep flowing at one per cycle while it drains. A line end waits
// in the input register until the buffer is empty or its last result is being
// taken. A length or illegal-character error gives a single result and stops
// the block until reset; further characters are then taken and dropped.
`include "hex_line_to_le_bytes_top_macros.svh"

module hex_line_to_le_bytes_top (
	input  logic             clk,
	input  logic             arst_n,
	hlb_in_if.sink           text,
	hlb_out_if.source        result
);
	import hlb_pkg::*;

	logic       v_s1;
	logic [7:0] char_s1;
	logic       eot_s1;

	line_t line_q;
	logic  halted_q;

	logic [STORE_DEPTH-1:0][7:0] res_data_q;
	kind_t      res_kind_q;
	logic [2:0] res_n_q;
	logic [1:0] res_idx_q;

	logic  is_end;
	logic  buf_free;
	logic  consume;
	logic  out_fire;
	line_t step_line;
	line_t fin_line;
	logic  len_ok;
	logic  fin_err;
	logic  load;
	logic [2:0] load_n;
	kind_t load_kind;
	logic [STORE_DEPTH-1:0][7:0] load_data;

	assign out_fire = result.valid && result.ready;
	assign is_end = eot_s1 || (char_s1 == CH_LF);
	assign buf_free = (res_n_q == 3'd0) || ((res_n_q == 3'd1) && result.ready);
	assign consume = v_s1 && (halted_q || !is_end || buf_free);
	assign text.ready = !v_s1 || consume;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (text.ready) begin
			v_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.valid && text.ready) begin
			char_s1 <= text.char_in;
			eot_s1 <= text.end_of_text;
		end
	end

	always_comb begin
		step_line = char_step(line_q, char_s1);
		fin_line = finish_prefix(line_q);
		len_ok = (fin_line.dcount == 4'd0) ||
			(((fin_line.dcount == 4'd2) || (fin_line.dcount == 4'd4) ||
			(fin_line.dcount == 4'd8)) &&
			({1'b0, fin_line.dcount[3:1]} <= 4'(MAX_BYTES)));
		fin_err = !len_ok || fin_line.bad;
		load_data = '0;
		load_kind = KIND_DATA;
		load_n = 3'd0;
		if (!len_ok) begin
			load_kind = KIND_LEN;
			load_n = 3'd1;
		end else if (fin_line.bad) begin
			load_kind = KIND_CHAR;
			load_n = 3'd1;
			load_data[0] = fin_line.badval;
		end else begin
			load_n = fin_line.dcount[3:1];
			// reverse byte order
			unique case (fin_line.dcount)
				4'd2: begin
					load_data[0] = fin_line.store[0];
				end
				4'd4: begin
					load_data[0] = fin_line.store[1];
					load_data[1] = fin_line.store[0];
				end
				4'd8: begin
					load_data[0] = fin_line.store[3];
					load_data[1] = fin_line.store[2];
					load_data[2] = fin_line.store[1];
					load_data[3] = fin_line.store[0];
				end
				default: begin
					load_data = '0;
				end
			endcase
		end
		load = consume && !halted_q && is_end && (load_n != 3'd0);
	end

	// line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q <= '0;
			halted_q <= 1'b0;
		end else if (consume && !halted_q) begin
			if (is_end) begin
				line_q <= clear_line(line_q);
				halted_q <= fin_err;
			end else begin
				line_q <= step_line;
			end
		end
	end

	// result buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_n_q <= 3'd0;
			res_idx_q <= 2'd0;
		end else if (load) begin
			res_n_q <= load_n;
			res_idx_q <= 2'd0;
		end else if (out_fire) begin
			res_n_q <= res_n_q - 3'd1;
			res_idx_q <= res_idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_data_q <= load_data;
			res_kind_q <= load_kind;
		end
	end

	assign result.valid = (res_n_q != 3'd0);
	assign result.out_value = res_data_q[res_idx_q];
	assign result.out_kind = res_kind_q;
	assign result.out_last = (res_n_q == 3'd1);

	`HLB_ASSERT_NEXT(a_error_halts, load && (load_kind != KIND_DATA), halted_q)
	`HLB_ASSERT_NEXT(a_halt_sticky, halted_q, halted_q && !result.valid || halted_q)
	`HLB_ASSERT_SAME(a_no_overwrite, load,
		(res_n_q == 3'd0) || ((res_n_q == 3'd1) && out_fire))
	`HLB_ASSERT_SAME(a_buf_bound, res_n_q != 3'd0,
		({2'b00, res_idx_q} + {1'b0, res_n_q}) <= 4'(STORE_DEPTH))

endmodule

### tb/hex_line_to_le_bytes_checker.sv
module hex_line_to_le_bytes_checker (
	input  logic clk,
	input  logic arst_n,
	hlb_in_if    text,
	hlb_out_if   result,
	output int   fail_count,
	output int   expected_left,
	output int   results_seen
);
	timeunit 1ns;
	timeprecision 1ps;
	import hlb_pkg::*;

	typedef struct packed {
		logic [7:0] value;
		kind_t      kind;
		logic       last;
	} result_t;

	result_t    pending_results[$];

	// line state of the decoder as seen from outside
	logic [7:0] line_bytes [MAX_BYTES];
	logic [3:0] hi_nibble;
	logic [3:0] digits_seen;
	logic [1:0] raw_pos;
	pre_t       prefix_state;
	logic       have_bad;
	logic [7:0] bad_code;
	logic       stopped;

	function automatic int nibble_of(logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39) begin
			return int'(c) - 'h30;
		end
		if (c >= 8'h61 && c <= 8'h66) begin
			return int'(c) - 'h61 + 10;
		end
		if (c >= 8'h41 && c <= 8'h46) begin
			return int'(c) - 'h41 + 10;
		end
		return -1;
	endfunction

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $time, what);
		fail_count++;
	endtask

	task automatic clear_line_state();
		hi_nibble = 4'd0;
		digits_seen = 4'd0;
		raw_pos = 2'd0;
		prefix_state = PRE_NONE;
		have_bad = 1'b0;
		bad_code = 8'd0;
	endtask

	// one character past prefix handling; blanks vanish, count saturates at 9
	task automatic absorb_char(input logic [7:0] c);
		logic [3:0] pos;
		int v;
		if (c == CH_SP || c == CH_TAB || c == CH_CR) begin
			return;
		end
		pos = digits_seen;
		if (digits_seen < 4'd9) begin
			digits_seen++;
		end
		v = nibble_of(c);
		if (v < 0) begin
			if (!have_bad) begin
				have_bad = 1'b1;
				bad_code = c;
			end
			return;
		end
		if (!pos[0]) begin
			hi_nibble = v[3:0];
		end else if (int'(pos >> 1) < MAX_BYTES) begin
			line_bytes[int'(pos >> 1)] = {hi_nibble, v[3:0]};
		end
	endtask

	task automatic close_line();
		int nb;
		result_t r;
		if (prefix_state == PRE_ZERO) begin
			absorb_char(CH_ZERO);
		end else if (prefix_state == PRE_ZX) begin
			absorb_char(CH_ZERO);
			absorb_char(CH_LX);
		end
		nb = int'(digits_seen) / 2;
		if (!(digits_seen == 4'd0 || ((digits_seen == 4'd2 || digits_seen == 4'd4 ||
				digits_seen == 4'd8) && nb <= MAX_BYTES))) begin
			r.value = 8'd0;
			r.kind = KIND_LEN;
			r.last = 1'b1;
			pending_results.push_back(r);
			stopped = 1'b1;
		end else if (have_bad) begin
			r.value = bad_code;
			r.kind = KIND_CHAR;
			r.last = 1'b1;
			pending_results.push_back(r);
			stopped = 1'b1;
		end else begin
			for (int k = 0; k < nb; k++) begin
				r.value = line_bytes[nb - 1 - k];
				r.kind = KIND_DATA;
				r.last = (k == nb - 1);
				pending_results.push_back(r);
			end
		end
		clear_line_state();
	endtask

	task automatic predict_char(input logic [7:0] c, input logic eot);
		if (stopped) begin
			return;
		end
		if (eot || c == CH_LF) begin
			close_line();
			return;
		end
		if (raw_pos == 2'd0) begin
			if (c == CH_ZERO) begin
				prefix_state = PRE_ZERO;
			end else begin
				absorb_char(c);
			end
		end else if (raw_pos == 2'd1 && prefix_state == PRE_ZERO) begin
			if (c == CH_LX || c == CH_UX) begin
				prefix_state = PRE_ZX;
			end else begin
				prefix_state = PRE_NONE;
				absorb_char(CH_ZERO);
				absorb_char(c);
			end
		end else begin
			if (prefix_state == PRE_ZX) begin
				prefix_state = PRE_NONE;
			end
			absorb_char(c);
		end
		if (raw_pos < 2'd2) begin
			raw_pos++;
		end
	endtask

	task automatic check_result();
		result_t want;
		if (pending_results.size() == 0) begin
			report_mismatch($sformatf("result with nothing expected: value %h kind %0d last %b",
				result.out_value, result.out_kind, result.out_last));
			return;
		end
		want = pending_results.pop_front();
		results_seen++;
		if (result.out_value !== want.value) begin
			report_mismatch($sformatf("out_value %h, expected %h", result.out_value, want.value));
		end
		if (result.out_kind !== want.kind) begin
			report_mismatch($sformatf("out_kind %0d, expected %0d", result.out_kind, want.kind));
		end
		if (result.out_last !== want.last) begin
			report_mismatch($sformatf("out_last %b, expected %b", result.out_last, want.last));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (line_bytes[i]) begin
				line_bytes[i] = 8'd0;
			end
			clear_line_state();
			stopped = 1'b0;
			pending_results.delete();
			fail_count = 0;
			results_seen = 0;
			expected_left <= 0;
		end else begin
			if (result.valid && result.ready) begin
				check_result();
			end
			if (text.valid && text.ready) begin
				predict_char(text.char_in, text.end_of_text);
			end
			expected_left <= pending_results.size();
		end
	end

endmodule

### tb/hex_line_to_le_bytes_top_tb.sv
module hex_line_to_le_bytes_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import hlb_pkg::*;

	localparam string HEX_SET = "0123456789abcdefABCDEF";
	localparam string BEYOND_F = "GHIJKLMNOPQRSTUVWXYZghijklmnopqrstuvwxyz";
	localparam string PUNCT = "!#$%&*+,-./:;<=>?@[]^_{|}~";

	logic clk = 1'b0;
	logic arst_n;

	hlb_in_if  text_ch ();
	hlb_out_if result_ch ();

	int fail_count;
	int expected_left;
	int results_seen;

	int chars_sent;
	int lines_sent;
	int burst_left;
	int stall_mode;
	int stall_left;
	bit paused_once;
	string closing_case;
	logic [7:0] line_buf[$];

	hex_line_to_le_bytes_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_ch),
		.result (result_ch)
	);

	hex_line_to_le_bytes_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.text          (text_ch),
		.result        (result_ch),
		.fail_count    (fail_count),
		.expected_left (expected_left),
		.results_seen  (results_seen)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// receiver: runs of always-ready, coin-flip, sparse and hard stall
	initial begin
		result_ch.ready <= 1'b0;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (stall_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				stall_left = (stall_mode == 3) ? $urandom_range(1, 12) : $urandom_range(5, 60);
			end
			stall_left--;
			case (stall_mode)
				0: result_ch.ready <= 1'b1;
				1: result_ch.ready <= 1'($urandom_range(0, 1));
				2: result_ch.ready <= ($urandom_range(0, 5) == 0);
				default: result_ch.ready <= 1'b0;
			endcase
		end
	end

	function automatic logic [7:0] hex_char();
		return HEX_SET[$urandom_range(0, 21)];
	endfunction

	function automatic logic [7:0] blank_char();
		case ($urandom_range(0, 2))
			0: return CH_SP;
			1: return CH_TAB;
			default: return CH_CR;
		endcase
	endfunction

	// sender works in bursts; valid stays high across a burst
	task automatic send_item(input logic [7:0] c, input logic eot);
		if (burst_left == 0) begin
			text_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) :
				$urandom_range(1, 10);
		end
		text_ch.valid <= 1'b1;
		text_ch.char_in <= c;
		text_ch.end_of_text <= eot;
		do @(posedge clk); while (!text_ch.ready);
		burst_left--;
		chars_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			send_item(s[i], 1'b0);
		end
	endtask

	// end_of_text carries a random character that the block must ignore
	task automatic end_line(input bit use_eot);
		if (use_eot) begin
			send_item(8'($urandom_range(0, 255)), 1'b1);
		end else begin
			send_item(CH_LF, 1'b0);
		end
		lines_sent++;
	endtask

	task automatic send_line_buf(input bit use_eot);
		foreach (line_buf[i]) begin
			send_item(line_buf[i], 1'b0);
		end
		end_line(use_eot);
	endtask

	task automatic wait_idle(input int hold);
		text_ch.valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (expected_left != 0) @(posedge clk);
		repeat (hold) @(posedge clk);
	endtask

	// legal line: 0, 1, 2 or 4 bytes, optional prefix, blanks after the prefix
	task automatic send_good_line();
		int pick;
		int nbytes;
		bit has_prefix;
		line_buf.delete();
		pick = $urandom_range(0, 9);
		nbytes = (pick < 1) ? 0 : (pick < 4) ? 1 : (pick < 7) ? 2 : 4;
		has_prefix = ($urandom_range(0, 2) == 0);
		if (has_prefix) begin
			line_buf.push_back(CH_ZERO);
			line_buf.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
			// a bare 0x would be an error, so pad it
			if (nbytes == 0) begin
				line_buf.push_back(blank_char());
			end
		end
		for (int i = 0; i < 2 * nbytes; i++) begin
			if ($urandom_range(0, 5) == 0) begin
				line_buf.push_back(blank_char());
			end
			line_buf.push_back(hex_char());
		end
		if ($urandom_range(0, 3) == 0) begin
			line_buf.push_back(blank_char());
		end
		send_line_buf($urandom_range(0, 3) == 0);
	endtask

	// the block stops for good after this line, save when a drawn x after a leading 0 makes a legal 0x line
	task automatic send_breaking_line();
		int n;
		line_buf.delete();
		case ($urandom_range(0, 5))
			0: begin
				closing_case = "odd digit count";
				n = 2 * $urandom_range(0, 3) + 1;
			end
			1: begin
				closing_case = "too many digits";
				n = $urandom_range(10, 14);
			end
			2: begin
				closing_case = "letter past f";
				n = 2 << $urandom_range(0, 2);
			end
			3: begin
				closing_case = "bare 0x prefix";
				n = 0;
			end
			4: begin
				closing_case = "non-hex byte";
				n = 2 << $urandom_range(0, 2);
			end
			default: begin
				closing_case = "odd count with a bad letter";
				n = 2 * $urandom_range(1, 2) + 1;
			end
		endcase
		repeat (n) line_buf.push_back(hex_char());
		if (closing_case == "bare 0x prefix") begin
			line_buf.push_back(CH_ZERO);
			line_buf.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
		end else if (closing_case == "non-hex byte") begin
			line_buf[$urandom_range(0, n - 1)] = $urandom_range(0, 1) ?
				8'($urandom_range(128, 255)) : PUNCT[$urandom_range(0, PUNCT.len() - 1)];
		end else if (closing_case == "letter past f" ||
				closing_case == "odd count with a bad letter") begin
			line_buf[$urandom_range(0, n - 1)] = BEYOND_F[$urandom_range(0, 39)];
		end
		send_line_buf(1'($urandom_range(0, 1)));
	endtask

	initial begin
		arst_n <= 1'b0;
		text_ch.valid <= 1'b0;
		text_ch.char_in <= 8'd0;
		text_ch.end_of_text <= 1'b0;
		chars_sent = 0;
		lines_sent = 0;
		burst_left = 0;
		paused_once = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty line, minimum byte, both prefixes, mixed case, blanks, end of text
		end_line(1'b0);
		send_text("00");
		end_line(1'b0);
		send_text("0xAbCd");
		end_line(1'b0);
		send_text("0X");
		send_item(CH_SP, 1'b0);
		send_text("9aF0");
		send_item(CH_TAB, 1'b0);
		send_item(CH_CR, 1'b0);
		end_line(1'b0);
		send_text("12345678");
		end_line(1'b1);

		while (chars_sent < 420) begin
			case ($urandom_range(0, 19))
				0: end_line(1'b0);
				1: begin
					repeat ($urandom_range(1, 3)) send_item(blank_char(), 1'b0);
					end_line(1'($urandom_range(0, 1)));
				end
				2: end_line(1'b1);
				default: send_good_line();
			endcase
			if (!paused_once && chars_sent > 250) begin
				paused_once = 1'b1;
				wait_idle($urandom_range(0, 10));
			end
		end

		send_breaking_line();
		// everything after the error must be swallowed
		send_item(8'hFF, 1'b0);
		send_item(8'h00, 1'b0);
		repeat (18) send_item(8'($urandom_range(0, 255)), $urandom_range(0, 4) == 0);
		send_text("12");
		end_line(1'b0);

		wait_idle(24);
		$display("covered %0d characters in %0d lines, %0d results checked", chars_sent,
			lines_sent, results_seen);
		$display("run closed on the %s case, then input while stopped", closing_case);
		if (fail_count == 0 && expected_left == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin
		#2ms;
		$display("timeout at %0t", $time);
		$display("status: fail");
		$finish;
	end

endmodule
